// File: sv/mcdm_pkg.sv
// Shared types and constants for the multichannel to mono downmix block.
// No dependencies; every other file imports this package.
`default_nettype none

package mcdm_pkg;

  // Width of one serial digit moved per cycle through the datapath
  localparam int DIGIT_W = 4;

  // Configuration register widths and indexes
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIX_MODE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  localparam logic                 MODE_PEAK     = 1'b1;
  localparam logic [CNT_W-1:0]     COUNT_RESET   = 4'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_COMMIT,
    S_ABS,
    S_DIV,
    S_NEG,
    S_OUT
  } state_t;

  // Operations of the serial accumulator
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ADD_FIRST,
    OP_ADD,
    OP_NEG,
    OP_DIV
  } sum_op_t;

  typedef struct packed {
    sum_op_t op;
    logic    first;     // first digit of a pass
  } sum_ctl_t;

  typedef struct packed {
    logic active;       // magnitude digit pass running
    logic first_dig;    // first digit of the pass
    logic first_chan;   // beat is channel zero of its frame
    logic commit;       // take the candidate if it won
  } peak_ctl_t;

endpackage

`default_nettype wire

// File: sv/mcdm_div.sv
// Digit-serial restoring divider by the small channel count, MSB digit first.
// Depends on mcdm_pkg.
`default_nettype none

module mcdm_div
  import mcdm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic               first,
  input  wire logic [CNT_W-1:0]   count,
  input  wire logic [DIGIT_W-1:0] num_digit,
  output logic      [DIGIT_W-1:0] q_digit
);

  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] rem_nxt;

  // One restoring step per bit of the digit; remainder stays below count
  always_comb begin
    logic [CNT_W-1:0] r;
    logic [CNT_W:0]   t;
    r       = first ? '0 : rem_r;
    q_digit = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, num_digit[i]};
      if (t >= {1'b0, count}) begin
        q_digit[i] = 1'b1;
        t          = t - {1'b0, count};
      end
      r = t[CNT_W-1:0];
    end
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/mcdm_sum.sv
// Rotating accumulator: serial add, serial negate and quotient shift-in.
// Depends on mcdm_pkg.
`default_nettype none

module mcdm_sum
  import mcdm_pkg::*;
#(
  parameter int ACC_W = 28
) (
  input  wire logic               clk,
  input  wire sum_ctl_t           ctl,
  input  wire logic [DIGIT_W-1:0] smp_digit,
  input  wire logic [DIGIT_W-1:0] q_digit,
  output logic      [ACC_W-1:0]   acc_q
);

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             carry_r;
  logic             carry_nxt;

  // Digit arithmetic on the low digit, LSB first; quotient enters at the bottom
  always_comb begin
    logic             cin;
    logic [DIGIT_W:0] s;
    cin       = ctl.first ? (ctl.op == OP_NEG) : carry_r;
    s         = '0;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    case (ctl.op)
      OP_ADD_FIRST: begin
        s = {1'b0, smp_digit} + {{DIGIT_W{1'b0}}, cin};
      end
      OP_ADD: begin
        s = {1'b0, acc_r[DIGIT_W-1:0]} + {1'b0, smp_digit} + {{DIGIT_W{1'b0}}, cin};
      end
      OP_NEG: begin
        s = {1'b0, ~acc_r[DIGIT_W-1:0]} + {{DIGIT_W{1'b0}}, cin};
      end
      default: begin
        s = '0;
      end
    endcase
    case (ctl.op)
      OP_ADD_FIRST, OP_ADD, OP_NEG: begin
        acc_nxt   = {s[DIGIT_W-1:0], acc_r[ACC_W-1:DIGIT_W]};
        carry_nxt = s[DIGIT_W];
      end
      OP_DIV: begin
        acc_nxt = {acc_r[ACC_W-DIGIT_W-1:0], q_digit};
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    carry_r <= carry_nxt;
  end

  assign acc_q = acc_r;

endmodule

`default_nettype wire

// File: sv/mcdm_peak.sv
// Serial magnitude and compare unit tracking the frame's largest sample.
// Depends on mcdm_pkg.
`default_nettype none

module mcdm_peak
  import mcdm_pkg::*;
#(
  parameter int ACC_W       = 28,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire peak_ctl_t              ctl,
  input  wire logic [DIGIT_W-1:0]     smp_digit,
  input  wire logic [SAMPLE_BITS-1:0] hold_sample,
  output logic      [SAMPLE_BITS-1:0] best_sample
);

  logic [ACC_W-1:0]       cand_r;
  logic [ACC_W-1:0]       bmag_r;
  logic [SAMPLE_BITS-1:0] best_r;
  logic                   carry_r;
  logic                   gt_r;
  logic [DIGIT_W-1:0]     m;
  logic [DIGIT_W-1:0]     b;
  logic                   carry_nxt;
  logic                   gt_nxt;

  // Magnitude digit by serial negation, then LSB-first greater-than chain
  always_comb begin
    logic             cin;
    logic             gt_in;
    logic [DIGIT_W:0] s;
    cin   = ctl.first_dig ? 1'b1 : carry_r;
    gt_in = ctl.first_dig ? 1'b0 : gt_r;
    s     = {1'b0, ~smp_digit} + {{DIGIT_W{1'b0}}, cin};
    if (hold_sample[SAMPLE_BITS-1]) begin
      m = s[DIGIT_W-1:0];
    end else begin
      m = smp_digit;
    end
    carry_nxt = s[DIGIT_W];
    b         = bmag_r[DIGIT_W-1:0];
    gt_nxt    = (m > b) | ((m == b) & gt_in);
  end

  // Rotate during the pass; on commit the candidate replaces the best if it won or is channel zero
  always_ff @(posedge clk) begin
    if (ctl.active) begin
      cand_r  <= {m, cand_r[ACC_W-1:DIGIT_W]};
      bmag_r  <= {b, bmag_r[ACC_W-1:DIGIT_W]};
      carry_r <= carry_nxt;
      gt_r    <= gt_nxt;
    end else if (ctl.commit && (ctl.first_chan || gt_r)) begin
      bmag_r <= cand_r;
      best_r <= hold_sample;
    end
  end

  assign best_sample = best_r;

endmodule

`default_nettype wire

// File: sv/multichannel_to_mono_downmix.sv
// Top level of the multichannel to mono downmix: sequencer, config and output beat.
// Depends on mcdm_pkg, mcdm_sum, mcdm_peak and mcdm_div.
`default_nettype none

// Interleaved signed samples enter one beat at a time; after the last channel of
// each frame (channel_count, 1 to MAX_CHANNELS) one mono beat leaves, either the
// mean of the frame truncated toward zero (mix_mode 0) or the sample of largest
// magnitude with its sign, earlier channel winning ties (mix_mode 1). The datapath
// is digit-serial, 4 bits a cycle, over NDIG = ceil((SAMPLE_BITS +
// clog2(MAX_CHANNELS)) / 4) digits, 7 at the default widths. Each input beat goes
// through accept, the add and magnitude-compare pass, and commit. A frame close adds
// the output step; in mean mode it is preceded by the serial divide pass, and for a
// negative sum the sum is negated before the divide and the quotient after it. The
// output register holds a finished beat while the next input is taken.
// Configuration is written through cfg_we.
module multichannel_to_mono_downmix
  import mcdm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_end_of_block,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed      [SAMPLE_BITS-1:0] out_mono_sample,
  output logic                               out_last_of_block,
  input  wire logic                          cfg_we,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic        [CFG_DAT_W-1:0]   cfg_data
);

  localparam int LOG_MAXC = $clog2(MAX_CHANNELS);
  localparam int SUM_BITS = SAMPLE_BITS + LOG_MAXC;
  localparam int NDIG     = (SUM_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int ACC_W    = NDIG * DIGIT_W;
  localparam int DIG_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int POS_W    = (MAX_CHANNELS > 1) ? LOG_MAXC : 1;
  localparam int CMP_W    = CNT_W + 1;
  localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(NDIG - 1);
  localparam logic [CMP_W-1:0] MAXC_W   = CMP_W'(MAX_CHANNELS);

  state_t state_r, state_nxt;

  logic                   mode_r;
  logic [CNT_W-1:0]       count_r;
  logic [POS_W-1:0]       pos_r;
  logic [DIG_W-1:0]       dig_r;
  logic [ACC_W-1:0]       smp_r;
  logic [SAMPLE_BITS-1:0] hold_r;
  logic                   eob_r;
  logic                   first_r;
  logic                   neg_r;
  logic                   sel_peak_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_mono_r;
  logic                   out_last_r;

  logic [CNT_W-1:0]       eff_count;
  logic                   close;
  logic                   last_dig;
  logic                   out_free;
  logic                   accept;
  logic                   pass_go;
  logic                   div_go;
  logic                   commit;
  logic                   out_load;
  sum_ctl_t               sum_ctl;
  peak_ctl_t              peak_ctl;
  logic [ACC_W-1:0]       acc_q;
  logic [DIGIT_W-1:0]     q_digit;
  logic [SAMPLE_BITS-1:0] best_sample;

  // Effective channel count and frame close test
  always_comb begin
    logic [CMP_W-1:0] cc;
    logic [CMP_W-1:0] eff;
    cc = {1'b0, count_r};
    if (count_r == '0) begin
      eff = CMP_W'(1);
    end else if (cc > MAXC_W) begin
      eff = MAXC_W;
    end else begin
      eff = cc;
    end
    eff_count = eff[CNT_W-1:0];
    close     = (CMP_W'(pos_r) + CMP_W'(1)) >= eff;
  end

  assign last_dig = (dig_r == LAST_DIG);
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_ACC;
      end
      S_ACC: begin
        if (last_dig) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!close) begin
          state_nxt = S_IDLE;
        end else if (mode_r == MODE_PEAK) begin
          state_nxt = S_OUT;
        end else if (acc_q[ACC_W-1]) begin
          state_nxt = S_ABS;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_ABS: begin
        if (last_dig) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (last_dig) state_nxt = neg_r ? S_NEG : S_OUT;
      end
      S_NEG: begin
        if (last_dig) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall            = 1'b1;
    accept              = 1'b0;
    pass_go             = 1'b0;
    div_go              = 1'b0;
    commit              = 1'b0;
    out_load            = 1'b0;
    sum_ctl.op          = OP_HOLD;
    sum_ctl.first       = (dig_r == '0);
    peak_ctl.active     = 1'b0;
    peak_ctl.first_dig  = (dig_r == '0);
    peak_ctl.first_chan = first_r;
    peak_ctl.commit     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // input held off while in reset
        in_stall = !rst_n;
        accept   = in_valid && rst_n;
      end
      S_ACC: begin
        pass_go         = 1'b1;
        sum_ctl.op      = first_r ? OP_ADD_FIRST : OP_ADD;
        peak_ctl.active = 1'b1;
      end
      S_COMMIT: begin
        commit          = 1'b1;
        peak_ctl.commit = 1'b1;
      end
      S_ABS, S_NEG: begin
        pass_go    = 1'b1;
        sum_ctl.op = OP_NEG;
      end
      S_DIV: begin
        pass_go    = 1'b1;
        div_go     = 1'b1;
        sum_ctl.op = OP_DIV;
      end
      S_OUT: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      count_r     <= COUNT_RESET;
      pos_r       <= '0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIX_MODE:      mode_r  <= cfg_data[0];
          CFG_CHANNEL_COUNT: count_r <= cfg_data[CNT_W-1:0];
          default:           mode_r  <= mode_r;
        endcase
      end
      if (pass_go && !last_dig) begin
        dig_r <= dig_r + DIG_W'(1);
      end else begin
        dig_r <= '0;
      end
      if (commit) begin
        pos_r <= close ? '0 : pos_r + POS_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: sample shift line, frame flags and output beat
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r   <= ACC_W'(in_sample);
      hold_r  <= in_sample;
      eob_r   <= in_end_of_block;
      first_r <= (pos_r == '0);
    end else if (state_r == S_ACC) begin
      smp_r <= {{DIGIT_W{smp_r[ACC_W-1]}}, smp_r[ACC_W-1:DIGIT_W]};
    end
    if (commit) begin
      neg_r      <= acc_q[ACC_W-1];
      sel_peak_r <= (mode_r == MODE_PEAK);
    end
    if (out_load) begin
      out_mono_r <= sel_peak_r ? best_sample : acc_q[SAMPLE_BITS-1:0];
      out_last_r <= eob_r;
    end
  end

  mcdm_sum #(
    .ACC_W (ACC_W)
  ) u_sum (
    .clk       (clk),
    .ctl       (sum_ctl),
    .smp_digit (smp_r[DIGIT_W-1:0]),
    .q_digit   (q_digit),
    .acc_q     (acc_q)
  );

  mcdm_peak #(
    .ACC_W       (ACC_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_peak (
    .clk         (clk),
    .ctl         (peak_ctl),
    .smp_digit   (smp_r[DIGIT_W-1:0]),
    .hold_sample (hold_r),
    .best_sample (best_sample)
  );

  mcdm_div u_div (
    .clk       (clk),
    .en        (div_go),
    .first     (dig_r == '0),
    .count     (eff_count),
    .num_digit (acc_q[ACC_W-1 -: DIGIT_W]),
    .q_digit   (q_digit)
  );

  assign out_valid         = out_valid_r;
  assign out_mono_sample   = out_mono_r;
  assign out_last_of_block = out_last_r;

endmodule

`default_nettype wire
